### rtl/circular_deque_macros.svh
// Assertion macros shared by the circular deque RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define CDQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// An antecedent that implies a consequent at the same edge.
`define CDQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An antecedent that implies a consequent at the next edge.
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque: command codes, controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdq_pkg;

  // Default number of bytes the deque can hold.
  localparam int DEF_CAPACITY = 14;

  // Command codes carried by each request.
  typedef enum logic [2:0] {
    CMD_PUSH_LEFT  = 3'd0,
    CMD_PUSH_RIGHT = 3'd1,
    CMD_POP_LEFT   = 3'd2,
    CMD_POP_RIGHT  = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;     // accept a request and update the deque state
    logic capture;  // latch the byte read from the ring
  } ctrl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic pop_hit;  // the offered request is a pop on a non-empty deque
  } stat_t;

endpackage

### rtl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended byte queue on a ring of CAPACITY+2 slots with push and pop at
// both ends, clear, and error reporting on overflow and underflow.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result. A push, clear,
// failed pop or unused code shows its result in the cycle after it is
// accepted; a successful pop passes through an extra read state because the
// byte comes from the ring RAM through its registered read port. The next
// request is accepted in the cycle after the result is taken. The ring needs
// no clearing pass: only written slots are ever read.
`timescale 1ns / 1ps

module circular_deque #(
  parameter int CAPACITY = cdq_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_cmd,
  input  logic [7:0]                    in_data_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_data_out,
  output logic                          out_error,
  output logic [$clog2(CAPACITY+1)-1:0] out_count,
  output logic                          out_is_empty,
  output logic                          out_is_full
);

  cdq_pkg::ctrl_t ctrl;
  cdq_pkg::stat_t stat;

  // Sequencing of accept, ring read and result.
  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Pointers, count, ring and result registers.
  cdq_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stat        (stat),
    .in_cmd      (in_cmd),
    .in_data_in  (in_data_in),
    .out_data_out(out_data_out),
    .out_error   (out_error),
    .out_count   (out_count),
    .out_is_empty(out_is_empty),
    .out_is_full (out_is_full)
  );

endmodule

### rtl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Controller of the circular deque: sequences accept, ring read and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "circular_deque_macros.svh"

module cdq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  cdq_pkg::stat_t  stat,
  output cdq_pkg::ctrl_t  ctrl
);

  cdq_pkg::state_t state_r;
  cdq_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: a successful pop passes through ST_READ for the ring read.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.pop_hit ? cdq_pkg::ST_READ : cdq_pkg::ST_OUT;
        end
      end
      cdq_pkg::ST_READ: begin
        state_nxt = cdq_pkg::ST_OUT;
      end
      cdq_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = cdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cdq_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    ctrl.load    = 1'b0;
    ctrl.capture = 1'b0;
    case (state_r)
      cdq_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      cdq_pkg::ST_READ: begin
        ctrl.capture = 1'b1;
      end
      cdq_pkg::ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Only one request is in flight at a time.
  `CDQ_ASSERT_ALWAYS(a_ready_xor_valid, !(in_ready && out_valid),
                     "input accepted while a result is pending")
  // A pop that hits is followed by the ring read cycle.
  `CDQ_ASSERT_NEXT(a_pop_reads, ctrl.load && stat.pop_hit, ctrl.capture,
                   "pop did not capture ring data")

endmodule

### rtl/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath
// Datapath of the circular deque: end pointers, fill count, byte ring and
// the result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "circular_deque_macros.svh"

module cdq_datapath #(
  parameter int CAPACITY = cdq_pkg::DEF_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cdq_pkg::ctrl_t                  ctrl,
  output cdq_pkg::stat_t                  stat,
  input  logic [2:0]                      in_cmd,
  input  logic [7:0]                      in_data_in,
  output logic [7:0]                      out_data_out,
  output logic                            out_error,
  output logic [$clog2(CAPACITY+1)-1:0]   out_count,
  output logic                            out_is_empty,
  output logic                            out_is_full
);

  localparam int Slots  = CAPACITY + 2;
  localparam int SlotW  = $clog2(Slots);
  localparam int CountW = $clog2(CAPACITY + 1);
  localparam logic [SlotW-1:0]  SlotLast = SlotW'(Slots - 1);
  localparam logic [SlotW-1:0]  LeftRst  = SlotW'(0);
  localparam logic [SlotW-1:0]  RightRst = SlotW'(1);
  localparam logic [CountW-1:0] CountMax = CountW'(CAPACITY);

  logic [SlotW-1:0]  left_r, left_nxt;
  logic [SlotW-1:0]  right_r, right_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [7:0]        data_r;
  logic              error_r, error_nxt;

  logic [SlotW-1:0]  left_inc, left_dec, right_inc, right_dec;
  logic              full, empty;
  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]        ram_rdata;
  cdq_pkg::cmd_t     cmd;

  assign cmd   = cdq_pkg::cmd_t'(in_cmd);
  assign full  = (count_r >= CountMax);
  assign empty = (count_r == '0);

  // Neighbor slots around the ring.
  assign left_inc  = (left_r == SlotLast) ? '0 : left_r + 1'b1;
  assign left_dec  = (left_r == '0) ? SlotLast : left_r - 1'b1;
  assign right_inc = (right_r == SlotLast) ? '0 : right_r + 1'b1;
  assign right_dec = (right_r == '0) ? SlotLast : right_r - 1'b1;

  // Command decode: next pointers, count, error and ring access.
  always_comb begin
    left_nxt     = left_r;
    right_nxt    = right_r;
    count_nxt    = count_r;
    error_nxt    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = left_r;
    ram_raddr    = left_inc;
    stat.pop_hit = 1'b0;
    case (cmd)
      cdq_pkg::CMD_PUSH_LEFT: begin
        if (full) begin
          error_nxt = 1'b1;
        end else begin
          ram_we    = ctrl.load;
          ram_waddr = left_r;
          left_nxt  = left_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      cdq_pkg::CMD_PUSH_RIGHT: begin
        if (full) begin
          error_nxt = 1'b1;
        end else begin
          ram_we    = ctrl.load;
          ram_waddr = right_r;
          right_nxt = right_inc;
          count_nxt = count_r + 1'b1;
        end
      end
      cdq_pkg::CMD_POP_LEFT: begin
        if (empty) begin
          error_nxt = 1'b1;
        end else begin
          stat.pop_hit = 1'b1;
          ram_raddr    = left_inc;
          left_nxt     = left_inc;
          count_nxt    = count_r - 1'b1;
        end
      end
      cdq_pkg::CMD_POP_RIGHT: begin
        if (empty) begin
          error_nxt = 1'b1;
        end else begin
          stat.pop_hit = 1'b1;
          ram_raddr    = right_dec;
          right_nxt    = right_dec;
          count_nxt    = count_r - 1'b1;
        end
      end
      cdq_pkg::CMD_CLEAR: begin
        left_nxt  = LeftRst;
        right_nxt = RightRst;
        count_nxt = '0;
      end
      default: begin
        error_nxt = 1'b0;
      end
    endcase
  end

  // Deque state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= LeftRst;
      right_r <= RightRst;
      count_r <= '0;
    end else if (ctrl.load) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      count_r <= count_nxt;
    end
  end

  // Result registers: error loaded and data cleared on accept, popped byte latched in the cycle after.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      error_r <= error_nxt;
      data_r  <= '0;
    end else if (ctrl.capture) begin
      data_r  <= ram_rdata;
    end
  end

  // Byte ring.
  cdq_ram #(
    .WIDTH(8),
    .DEPTH(Slots)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_data_in),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_data_out = data_r;
  assign out_error    = error_r;
  assign out_count    = count_r;
  assign out_is_empty = (count_r == '0);
  assign out_is_full  = (count_r == CountMax);

  // The count never passes the capacity.
  `CDQ_ASSERT_ALWAYS(a_count_bound, count_r <= CountMax, "fill count above capacity")
  // The stored bytes lie exactly between the two free end slots.
  `CDQ_ASSERT_ALWAYS(a_ptr_gap,
    ((32'(left_r) + 32'(count_r) + 32'd1) == 32'(right_r)) ||
    ((32'(left_r) + 32'(count_r) + 32'd1) == (32'(right_r) + 32'(Slots))),
    "end pointers disagree with fill count")
  // A failed request never returns a byte.
  `CDQ_ASSERT_IMPLY(a_err_no_data, out_error && !ctrl.load, out_data_out == '0,
                    "error result carries data")

endmodule

### bench/tb_circular_deque.sv
// ----------------------------------------------------------------------------
// tb_circular_deque
// Self-checking bench for the circular deque. Every accepted request goes
// through a bit-exact model of the ring, and the expected results are
// compared field by field with what the block returns. Directed requests
// cover empty and full edges, unused codes, clear and pointer wrap; random
// traffic then fills and drains the deque under varying idle and stall
// rates, including a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_circular_deque;

  localparam int CAPACITY = cdq_pkg::DEF_CAPACITY;
  localparam int RING_SLOTS = CAPACITY + 2;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [2:0] CMD_LAST_CODE = 3'd7;
  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;

  typedef struct {
    logic [7:0]    data;
    logic          error;
    logic [CW-1:0] count;
    logic          empty;
    logic          full;
  } deque_result_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [2:0]    in_cmd;
  logic [7:0]    in_data_in;
  logic          out_valid;
  logic          out_ready;
  logic [7:0]    out_data_out;
  logic          out_error;
  logic [CW-1:0] out_count;
  logic          out_is_empty;
  logic          out_is_full;

  // Model of the deque contents and pointers.
  logic [7:0]    ring_model [RING_SLOTS];
  int            front_gap;
  int            back_gap;
  int            fill_level;

  deque_result_t pending_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_left;
  int mismatch_count;
  int requests_sent;
  int results_checked;
  int error_results;
  int full_results;

  circular_deque #(.CAPACITY(CAPACITY)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data_out (out_data_out),
    .out_error    (out_error),
    .out_count    (out_count),
    .out_is_empty (out_is_empty),
    .out_is_full  (out_is_full)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit for the run.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Apply one command to the model and return the result it produces.
  function automatic deque_result_t predict_deque(logic [2:0] code, logic [7:0] byte_in);
    deque_result_t res;
    res.data  = '0;
    res.error = 1'b0;
    case (code)
      cdq_pkg::CMD_PUSH_LEFT: begin
        if (fill_level == CAPACITY) begin
          res.error = 1'b1;
        end else begin
          ring_model[front_gap] = byte_in;
          fill_level++;
          front_gap = (front_gap == 0) ? RING_SLOTS - 1 : front_gap - 1;
        end
      end
      cdq_pkg::CMD_PUSH_RIGHT: begin
        if (fill_level == CAPACITY) begin
          res.error = 1'b1;
        end else begin
          ring_model[back_gap] = byte_in;
          fill_level++;
          back_gap = (back_gap == RING_SLOTS - 1) ? 0 : back_gap + 1;
        end
      end
      cdq_pkg::CMD_POP_LEFT: begin
        if (fill_level == 0) begin
          res.error = 1'b1;
        end else begin
          front_gap = (front_gap == RING_SLOTS - 1) ? 0 : front_gap + 1;
          fill_level--;
          res.data = ring_model[front_gap];
        end
      end
      cdq_pkg::CMD_POP_RIGHT: begin
        if (fill_level == 0) begin
          res.error = 1'b1;
        end else begin
          back_gap = (back_gap == 0) ? RING_SLOTS - 1 : back_gap - 1;
          fill_level--;
          res.data = ring_model[back_gap];
        end
      end
      cdq_pkg::CMD_CLEAR: begin
        front_gap  = 0;
        back_gap   = 1;
        fill_level = 0;
      end
      default: begin
      end
    endcase
    res.count = CW'(fill_level);
    res.empty = (fill_level == 0);
    res.full  = (fill_level == CAPACITY);
    return res;
  endfunction

  // Offer one request, wait for its acceptance, then record the expectation.
  task automatic send_request(input logic [2:0] code, input logic [7:0] byte_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= code;
    in_data_in <= byte_in;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_deque(code, byte_in));
    requests_sent++;
  endtask

  // Output side: random stalls, long hold-offs, and the result check.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("Result with no request outstanding: data_out %0h", out_data_out);
          mismatch_count++;
        end else begin
          deque_result_t exp_res;
          exp_res = pending_results.pop_front();
          results_checked++;
          if (exp_res.error) error_results++;
          if (exp_res.full) full_results++;
          if (out_data_out !== exp_res.data) begin
            $error("data_out: expected %0h, got %0h", exp_res.data, out_data_out);
            mismatch_count++;
          end
          if (out_error !== exp_res.error) begin
            $error("error: expected %0b, got %0b", exp_res.error, out_error);
            mismatch_count++;
          end
          if (out_count !== exp_res.count) begin
            $error("count: expected %0d, got %0d", exp_res.count, out_count);
            mismatch_count++;
          end
          if (out_is_empty !== exp_res.empty) begin
            $error("is_empty: expected %0b, got %0b", exp_res.empty, out_is_empty);
            mismatch_count++;
          end
          if (out_is_full !== exp_res.full) begin
            $error("is_full: expected %0b, got %0b", exp_res.full, out_is_full);
            mismatch_count++;
          end
        end
      end
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left <= hold_off_left - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Pops and unused codes on the empty deque after reset.
  task automatic test_empty_edges();
    send_request(cdq_pkg::CMD_POP_LEFT, 8'hFF);
    send_request(cdq_pkg::CMD_POP_RIGHT, 8'h00);
    for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_CODE; c++) begin
      send_request(3'(c), 8'($urandom_range(255)));
    end
  endtask

  // Fill from both ends (the left pointer wraps at once), overflow, clear, then pop the cleared deque.
  task automatic test_fill_overflow_clear();
    logic [7:0] byte_val;
    for (int i = 0; i < CAPACITY; i++) begin
      byte_val = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(255));
      send_request((i % 2 == 0) ? cdq_pkg::CMD_PUSH_LEFT : cdq_pkg::CMD_PUSH_RIGHT,
                   byte_val);
    end
    send_request(cdq_pkg::CMD_PUSH_LEFT, 8'hA5);
    send_request(cdq_pkg::CMD_PUSH_RIGHT, 8'h5A);
    send_request(cdq_pkg::CMD_CLEAR, 8'h3C);
    send_request(cdq_pkg::CMD_POP_RIGHT, 8'hC3);
  endtask

  // Random traffic in tides of push-heavy, pop-heavy and balanced requests, with some clears and unused codes.
  task automatic test_random_traffic(input int n_requests);
    int         push_pct;
    int         pick;
    logic [2:0] code;
    push_pct = 50;
    for (int i = 0; i < n_requests; i++) begin
      if (i % 24 == 0) begin
        pick = $urandom_range(2);
        push_pct = (pick == 0) ? 85 : (pick == 1) ? 15 : 50;
      end
      pick = $urandom_range(99);
      if (pick < 2) begin
        code = cdq_pkg::CMD_CLEAR;
      end else if (pick < 5) begin
        code = 3'($urandom_range(CMD_LAST_CODE, CMD_FIRST_UNUSED));
      end else if ($urandom_range(99) < push_pct) begin
        code = $urandom_range(1) ? cdq_pkg::CMD_PUSH_LEFT : cdq_pkg::CMD_PUSH_RIGHT;
      end else begin
        code = $urandom_range(1) ? cdq_pkg::CMD_POP_LEFT : cdq_pkg::CMD_POP_RIGHT;
      end
      send_request(code, 8'($urandom_range(255)));
    end
  endtask

  // Long output hold-off while requests keep coming, so the input stalls.
  task automatic test_output_backpressure();
    hold_off_left = 300;
    for (int i = 0; i < 20; i++) begin
      send_request(($urandom_range(3) != 0) ? cdq_pkg::CMD_PUSH_RIGHT : cdq_pkg::CMD_POP_LEFT,
                   8'($urandom_range(255)));
    end
  endtask

  // Main sequence.
  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_cmd         <= cdq_pkg::CMD_PUSH_LEFT;
    in_data_in     <= '0;
    front_gap      = 0;
    back_gap       = 1;
    fill_level     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 0;
    mismatch_count = 0;
    requests_sent  = 0;
    results_checked = 0;
    error_results  = 0;
    full_results   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_edges();
    test_fill_overflow_clear();

    send_idle_pct  = 18;
    recv_stall_pct = 65;
    test_random_traffic(450);
    test_output_backpressure();

    send_idle_pct  = 65;
    recv_stall_pct = 18;
    test_random_traffic(450);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(460);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d requests with %0d results checked.", requests_sent,
             results_checked);
    $display("Results with overflow or underflow: %0d, with the deque full: %0d.",
             error_results, full_results);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/cdq_ctrl.sv
rtl/cdq_datapath.sv
rtl/circular_deque.sv
bench/tb_circular_deque.sv
